@@ rtl/sdf_pkg.sv @@
// Shared constants, character codes and the per-request format spec for the
// signed decimal field formatter. No dependencies.
package sdf_pkg;

  localparam int VALUE_W       = 32;
  localparam int DIGITS        = 10;
  localparam int BCD_W         = 4 * DIGITS;
  localparam int PREC_W        = 6;
  localparam int WIDTH_W       = 7;
  localparam int CHAR_W        = 8;
  localparam int LEN_W         = 7;
  localparam int MAX_FIELD_DEF = 64;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  // Format spec of one request, held by the top level while it is worked on.
  typedef struct packed {
    logic                has_sign;
    logic [CHAR_W-1:0]   sign_ch;
    logic                left;
    logic                zpad;
    logic                hasp;
    logic [PREC_W-1:0]   prec;
    logic [WIDTH_W-1:0]  width;
  } sdf_spec_t;

endpackage

@@ rtl/sdf_if.sv @@
// Valid/ready channel interfaces of the signed decimal field formatter.
// Depends on sdf_pkg for field widths.
interface sdf_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [sdf_pkg::VALUE_W-1:0] value;
  logic                              plus_flag;
  logic                              space_flag;
  logic                              left_flag;
  logic                              zero_flag;
  logic                              has_precision;
  logic [sdf_pkg::PREC_W-1:0]        precision;
  logic [sdf_pkg::WIDTH_W-1:0]       min_width;

  modport source (
    output valid, value, plus_flag, space_flag, left_flag, zero_flag,
           has_precision, precision, min_width,
    input  ready
  );
  modport sink (
    input  valid, value, plus_flag, space_flag, left_flag, zero_flag,
           has_precision, precision, min_width,
    output ready
  );
endinterface

interface sdf_out_if;
  logic                        valid;
  logic                        ready;
  logic [sdf_pkg::CHAR_W-1:0]  out_char;
  logic                        char_valid;
  logic                        last;
  logic [sdf_pkg::LEN_W-1:0]   total_length;

  modport source (
    output valid, out_char, char_valid, last, total_length,
    input  ready
  );
  modport sink (
    input  valid, out_char, char_valid, last, total_length,
    output ready
  );
endinterface

@@ rtl/sdf_b2bcd.sv @@
// Bit-serial binary to BCD converter (shift and add 3), two bits per cycle.
// Depends on sdf_pkg.
module sdf_b2bcd (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sdf_pkg::VALUE_W-1:0]   mag,
  output logic                          done,
  output logic [sdf_pkg::BCD_W-1:0]     bcd
);

  localparam int STEPS = sdf_pkg::VALUE_W / 2;
  localparam int SCW   = $clog2(STEPS);

  logic [sdf_pkg::VALUE_W-1:0] bin_r, bin_nxt;
  logic [sdf_pkg::BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [SCW-1:0]              cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;

  // Adjust every digit of five or more by three, then shift one bit in.
  function automatic logic [sdf_pkg::BCD_W-1:0] dabble(
    input logic [sdf_pkg::BCD_W-1:0] x,
    input logic                      b
  );
    logic [sdf_pkg::BCD_W-1:0] y;
    y = x;
    for (int k = 0; k < sdf_pkg::DIGITS; k++) begin
      if (y[4*k +: 4] >= 4'd5) y[4*k +: 4] = y[4*k +: 4] + 4'd3;
    end
    return {y[sdf_pkg::BCD_W-2:0], b};
  endfunction

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      bin_nxt  = mag;
      bcd_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bcd_nxt = dabble(dabble(bcd_r, bin_r[sdf_pkg::VALUE_W-1]), bin_r[sdf_pkg::VALUE_W-2]);
      bin_nxt = bin_r << 2;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == SCW'(STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

@@ rtl/sdf_emit.sv @@
// Field layout and character sequencer with the output register.
// Depends on sdf_pkg and sdf_out_if.
module sdf_emit #(
  parameter int MAX_FIELD = sdf_pkg::MAX_FIELD_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  sdf_pkg::sdf_spec_t         spec,
  input  logic [sdf_pkg::BCD_W-1:0]  bcd,
  output logic                       done,
  sdf_out_if.source                  out_chan
);

  localparam int CW = $clog2(MAX_FIELD + 1);
  localparam int XW = (CW > sdf_pkg::WIDTH_W) ? CW : sdf_pkg::WIDTH_W;

  typedef enum logic [3:0] {
    E_IDLE = 4'b0001,
    E_LAY1 = 4'b0010,
    E_LAY2 = 4'b0100,
    E_RUN  = 4'b1000
  } est_t;

  est_t                      state_r, state_nxt;
  logic [CW-1:0]             lead0_r, lead0_nxt;
  logic [CW-1:0]             len_r, len_nxt;
  logic [CW-1:0]             width_r, width_nxt;
  logic [3:0]                dig_r, dig_nxt;
  logic [sdf_pkg::BCD_W-1:0] dsr_r, dsr_nxt;
  logic [CW-1:0]             padl_r, padl_nxt;
  logic                      sign_r, sign_nxt;
  logic [CW-1:0]             zero_r, zero_nxt;
  logic [CW-1:0]             padr_r, padr_nxt;
  logic [CW-1:0]             rem_r, rem_nxt;
  logic [CW-1:0]             total_r, total_nxt;

  logic                       ov_r, ov_nxt;
  logic [sdf_pkg::CHAR_W-1:0] oc_r;
  logic                       ocv_r, olast_r;
  logic [sdf_pkg::LEN_W-1:0]  olen_r;

  logic                       load;
  logic [sdf_pkg::CHAR_W-1:0] ch;
  logic                       chv, lst;
  logic [sdf_pkg::LEN_W-1:0]  tl;
  logic                       slot_free;

  logic [3:0]                nd_c, sh_c;
  logic [XW-1:0]             prec_x, width_x;
  logic [CW-1:0]             prec_s, width_s, lead0_c, len_c;
  logic [sdf_pkg::BCD_W-1:0] dal_c;
  logic [CW-1:0]             pad_c;
  logic                      zmerge;

  // Significant digit count and the digits aligned to the top of the shifter.
  always_comb begin
    nd_c = 4'd1;
    for (int k = 0; k < sdf_pkg::DIGITS; k++) begin
      if (bcd[4*k +: 4] != 4'd0) nd_c = 4'(k + 1);
    end
    if (spec.hasp && spec.prec == '0 && bcd == '0) nd_c = 4'd0;
  end

  assign prec_x  = XW'(spec.prec);
  assign width_x = XW'(spec.width);
  assign prec_s  = (prec_x > XW'(MAX_FIELD - 1)) ? CW'(MAX_FIELD - 1) : CW'(prec_x);
  assign width_s = (width_x > XW'(MAX_FIELD)) ? CW'(MAX_FIELD) : CW'(width_x);
  assign lead0_c = (spec.hasp && prec_s > CW'(nd_c)) ? prec_s - CW'(nd_c) : '0;
  assign len_c   = CW'(spec.has_sign) + lead0_c + CW'(nd_c);
  assign sh_c    = 4'(sdf_pkg::DIGITS) - nd_c;
  assign dal_c   = bcd << {sh_c, 2'b00};

  assign pad_c  = (len_r < width_r) ? width_r - len_r : '0;
  assign zmerge = !spec.left && spec.zpad && !spec.hasp;

  assign slot_free = !ov_r || out_chan.ready;

  always_comb begin
    state_nxt = state_r;
    lead0_nxt = lead0_r;
    len_nxt   = len_r;
    width_nxt = width_r;
    dig_nxt   = dig_r;
    dsr_nxt   = dsr_r;
    padl_nxt  = padl_r;
    sign_nxt  = sign_r;
    zero_nxt  = zero_r;
    padr_nxt  = padr_r;
    rem_nxt   = rem_r;
    total_nxt = total_r;
    load      = 1'b0;
    ch        = '0;
    chv       = 1'b0;
    lst       = 1'b0;
    tl        = '0;
    done      = 1'b0;
    unique case (state_r)
      E_IDLE: begin
        if (start) state_nxt = E_LAY1;
      end
      E_LAY1: begin
        lead0_nxt = lead0_c;
        len_nxt   = len_c;
        width_nxt = width_s;
        dig_nxt   = nd_c;
        dsr_nxt   = dal_c;
        state_nxt = E_LAY2;
      end
      E_LAY2: begin
        padl_nxt  = (!spec.left && !zmerge) ? pad_c : '0;
        padr_nxt  = spec.left ? pad_c : '0;
        zero_nxt  = lead0_r + (zmerge ? pad_c : '0);
        sign_nxt  = spec.has_sign;
        rem_nxt   = len_r + pad_c;
        total_nxt = len_r + pad_c;
        state_nxt = E_RUN;
      end
      E_RUN: begin
        if (slot_free) begin
          load = 1'b1;
          if (rem_r == '0) begin
            // empty field: one marker with no character
            lst       = 1'b1;
            done      = 1'b1;
            state_nxt = E_IDLE;
          end else begin
            chv     = 1'b1;
            rem_nxt = rem_r - 1'b1;
            priority if (padl_r != '0) begin
              ch       = sdf_pkg::CH_SPACE;
              padl_nxt = padl_r - 1'b1;
            end else if (sign_r) begin
              ch       = spec.sign_ch;
              sign_nxt = 1'b0;
            end else if (zero_r != '0) begin
              ch       = sdf_pkg::CH_ZERO;
              zero_nxt = zero_r - 1'b1;
            end else if (dig_r != 4'd0) begin
              ch      = sdf_pkg::CH_ZERO + {4'b0000, dsr_r[sdf_pkg::BCD_W-1 -: 4]};
              dsr_nxt = dsr_r << 4;
              dig_nxt = dig_r - 4'd1;
            end else begin
              ch       = sdf_pkg::CH_SPACE;
              padr_nxt = padr_r - 1'b1;
            end
            if (rem_r == CW'(1)) begin
              lst       = 1'b1;
              tl        = sdf_pkg::LEN_W'(total_r);
              done      = 1'b1;
              state_nxt = E_IDLE;
            end
          end
        end
      end
      default: state_nxt = E_IDLE;
    endcase
  end

  assign ov_nxt = load ? 1'b1 : (out_chan.ready ? 1'b0 : ov_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    lead0_r <= lead0_nxt;
    len_r   <= len_nxt;
    width_r <= width_nxt;
    dig_r   <= dig_nxt;
    dsr_r   <= dsr_nxt;
    padl_r  <= padl_nxt;
    sign_r  <= sign_nxt;
    zero_r  <= zero_nxt;
    padr_r  <= padr_nxt;
    rem_r   <= rem_nxt;
    total_r <= total_nxt;
    if (load) begin
      oc_r    <= ch;
      ocv_r   <= chv;
      olast_r <= lst;
      olen_r  <= tl;
    end
  end

  assign out_chan.valid        = ov_r;
  assign out_chan.out_char     = oc_r;
  assign out_chan.char_valid   = ocv_r;
  assign out_chan.last         = olast_r;
  assign out_chan.total_length = olen_r;

endmodule

@@ rtl/signed_decimal_field_formatter_core.sv @@
// Top level of the signed decimal field formatter (printf %d conversion).
// Depends on sdf_pkg, sdf_if, sdf_b2bcd and sdf_emit.
//
// Each request on in_chan is one signed 32-bit value with its %d flags; the
// block answers with the formatted text on out_chan, one ASCII character per
// result, last set on the final one together with the total length. A field
// that comes out empty gives a single result with char_valid low. Requests
// are worked on one at a time: the magnitude goes through a bit-serial BCD
// converter that takes two bits a cycle and then flags completion, then a
// handoff into the sequencer and a layout step (E_LAY1, then E_LAY2) size the
// sign, zero and space runs, and the sequencer sends one character a cycle
// while out_chan is not stalled. No new request is accepted until the last
// character of the current one has been loaded into the output register, and
// back-pressure from the consumer delays both. The output register lets the
// last character wait for its consumer while the next request is already
// accepted.
module signed_decimal_field_formatter_core #(
  parameter int MAX_FIELD = sdf_pkg::MAX_FIELD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sdf_in_if.sink      in_chan,
  sdf_out_if.source   out_chan
);

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_CONV = 3'b010,
    T_EMIT = 3'b100
  } tst_t;

  tst_t                          state_r, state_nxt;
  sdf_pkg::sdf_spec_t            spec_r;
  sdf_pkg::sdf_spec_t            spec_c;
  logic [sdf_pkg::VALUE_W-1:0]   raw;
  logic [sdf_pkg::VALUE_W-1:0]   mag_c;
  logic                          accept;
  logic                          conv_done;
  logic                          emit_done;
  logic [sdf_pkg::BCD_W-1:0]     bcd;

  // Take a request only when nothing is in flight.
  assign in_chan.ready = (state_r == T_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;

  // Magnitude: negate in modulo arithmetic, which also covers the most
  // negative value (its magnitude fits in 32 unsigned bits).
  assign raw   = in_chan.value;
  assign mag_c = raw[sdf_pkg::VALUE_W-1] ? (sdf_pkg::VALUE_W'(0) - raw) : raw;

  // Sign character: minus wins, then plus, then space.
  always_comb begin
    spec_c.has_sign = 1'b1;
    priority if (raw[sdf_pkg::VALUE_W-1]) begin
      spec_c.sign_ch = sdf_pkg::CH_MINUS;
    end else if (in_chan.plus_flag) begin
      spec_c.sign_ch = sdf_pkg::CH_PLUS;
    end else if (in_chan.space_flag) begin
      spec_c.sign_ch = sdf_pkg::CH_SPACE;
    end else begin
      spec_c.sign_ch  = '0;
      spec_c.has_sign = 1'b0;
    end
    spec_c.left  = in_chan.left_flag;
    spec_c.zpad  = in_chan.zero_flag;
    spec_c.hasp  = in_chan.has_precision;
    spec_c.prec  = in_chan.precision;
    spec_c.width = in_chan.min_width;
  end

  // Request sequencing: convert, then hand over to the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_IDLE: if (accept) state_nxt = T_CONV;
      T_CONV: if (conv_done) state_nxt = T_EMIT;
      T_EMIT: if (emit_done) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    // hold the spec for the whole request
    if (accept) spec_r <= spec_c;
  end

  sdf_b2bcd u_b2bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .mag   (mag_c),
    .done  (conv_done),
    .bcd   (bcd)
  );

  // The converter result stays put until the next request starts it again.
  sdf_emit #(
    .MAX_FIELD (MAX_FIELD)
  ) u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (conv_done),
    .spec     (spec_r),
    .bcd      (bcd),
    .done     (emit_done),
    .out_chan (out_chan)
  );

  // The converter finishes only while a request is being converted.
  a_conv_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    conv_done |-> state_r == T_CONV)
    else $error("conversion finished outside the convert phase");

  // Finishing the sequencer frees the block for the next request.
  a_emit_frees: assert property (@(posedge clk) disable iff (!rst_n)
    emit_done |=> state_r == T_IDLE && in_chan.ready)
    else $error("block not ready after the last character");

  // An empty marker is always the sole, final result with zero length.
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.char_valid |->
      out_chan.last && out_chan.total_length == '0 && out_chan.out_char == '0)
    else $error("malformed empty marker");

  // Length appears only on the final result.
  a_len_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.last |-> out_chan.total_length == '0)
    else $error("length on a non-final result");

endmodule

@@ verif/sdf_tb_pkg.sv @@
`timescale 1ns / 100ps
// Request and result types plus the scoreboard for the decimal field formatter bench.
// Depends on sdf_pkg for character codes and field widths.
package sdf_tb_pkg;

  localparam int FIELD_MAX = sdf_pkg::MAX_FIELD_DEF;

  typedef struct packed {
    logic signed [sdf_pkg::VALUE_W-1:0] value;
    bit                                 plus;
    bit                                 space;
    bit                                 left;
    bit                                 zpad;
    bit                                 hasp;
    bit [sdf_pkg::PREC_W-1:0]           prec;
    bit [sdf_pkg::WIDTH_W-1:0]          width;
  } fmt_request_t;

  typedef struct packed {
    bit [sdf_pkg::CHAR_W-1:0] ch;
    bit                       ch_valid;
    bit                       is_last;
    bit [sdf_pkg::LEN_W-1:0]  total_len;
  } fmt_char_t;

  class decimal_text_scoreboard;
    fmt_char_t expected_chars[$];
    int        mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    task report(string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      mismatches++;
    endtask

    // Lay out the %d text of one request and queue its characters.
    function void format_decimal_field(fmt_request_t r);
      logic [sdf_pkg::VALUE_W-1:0] raw;
      logic [sdf_pkg::VALUE_W-1:0] mag;
      bit [sdf_pkg::CHAR_W-1:0]    digs[sdf_pkg::DIGITS];
      bit [sdf_pkg::CHAR_W-1:0]    text[$];
      bit [sdf_pkg::CHAR_W-1:0]    sign_ch;
      bit                          has_sign;
      int                          nd;
      int                          prec;
      int                          wid;
      int                          lead0;
      int                          pad;
      int                          body_len;
      fmt_char_t                   c;
      raw = r.value;
      mag = raw[sdf_pkg::VALUE_W-1] ? (32'd0 - raw) : raw;
      nd = 0;
      do begin
        digs[nd] = sdf_pkg::CH_ZERO + sdf_pkg::CHAR_W'(mag % 10);
        nd++;
        mag = mag / 10;
      end while (mag != 0 && nd < sdf_pkg::DIGITS);
      prec = (r.prec > FIELD_MAX - 1) ? FIELD_MAX - 1 : r.prec;
      wid = (r.width > FIELD_MAX) ? FIELD_MAX : r.width;
      if (r.hasp && prec == 0 && raw == 0) nd = 0;
      lead0 = (r.hasp && prec > nd) ? prec - nd : 0;
      has_sign = 1'b1;
      if (raw[sdf_pkg::VALUE_W-1]) sign_ch = sdf_pkg::CH_MINUS;
      else if (r.plus) sign_ch = sdf_pkg::CH_PLUS;
      else if (r.space) sign_ch = sdf_pkg::CH_SPACE;
      else begin
        has_sign = 1'b0;
        sign_ch = '0;
      end
      body_len = int'(has_sign) + lead0 + nd;
      pad = 0;
      if (body_len < wid) begin
        pad = wid - body_len;
        // zero fill replaces space fill only when right-justified without precision
        if (!r.left && r.zpad && !r.hasp) begin
          lead0 += pad;
          pad = 0;
        end
      end
      if (!r.left)
        for (int i = 0; i < pad && text.size() < FIELD_MAX; i++)
          text.push_back(sdf_pkg::CH_SPACE);
      if (has_sign && text.size() < FIELD_MAX) text.push_back(sign_ch);
      for (int i = 0; i < lead0 && text.size() < FIELD_MAX; i++)
        text.push_back(sdf_pkg::CH_ZERO);
      for (int i = nd; i > 0 && text.size() < FIELD_MAX; i--) text.push_back(digs[i-1]);
      if (r.left)
        for (int i = 0; i < pad && text.size() < FIELD_MAX; i++)
          text.push_back(sdf_pkg::CH_SPACE);
      if (text.size() == 0) begin
        c = '{ch: '0, ch_valid: 1'b0, is_last: 1'b1, total_len: '0};
        expected_chars.push_back(c);
      end else begin
        foreach (text[i]) begin
          c.ch = text[i];
          c.ch_valid = 1'b1;
          c.is_last = (i == text.size() - 1);
          c.total_len = c.is_last ? sdf_pkg::LEN_W'(text.size()) : '0;
          expected_chars.push_back(c);
        end
      end
    endfunction

    function void note_request(fmt_request_t r);
      format_decimal_field(r);
    endfunction

    task check_char(fmt_char_t got);
      fmt_char_t want;
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected result ch=%h valid=%0b last=%0b len=%0d",
                         got.ch, got.ch_valid, got.is_last, got.total_len));
        return;
      end
      want = expected_chars.pop_front();
      if (got.ch != want.ch || got.ch_valid != want.ch_valid ||
          got.is_last != want.is_last || got.total_len != want.total_len)
        report($sformatf({"got ch=%h valid=%0b last=%0b len=%0d, ",
                          "want ch=%h valid=%0b last=%0b len=%0d"},
                         got.ch, got.ch_valid, got.is_last, got.total_len,
                         want.ch, want.ch_valid, want.is_last, want.total_len));
    endtask
  endclass

endpackage

@@ verif/tb_signed_decimal_field_formatter_core.sv @@
`timescale 1ns / 100ps
// Testbench top for signed_decimal_field_formatter_core: directed and random %d requests,
// random idling on both channels. Depends on sdf_pkg, sdf_if and sdf_tb_pkg.
module tb_signed_decimal_field_formatter_core;

  localparam int RANDOM_REQUESTS = 140;
  localparam int DRAIN_CYCLES    = 200000;
  localparam int SETTLE_CYCLES   = 100;

  logic clk = 1'b0;
  logic rst_n;

  sdf_in_if  in_if ();
  sdf_out_if out_if ();

  sdf_tb_pkg::decimal_text_scoreboard sb;

  // Idle enables; each side redraws its own now and then so that some
  // stretches run back to back.
  bit send_idles;
  bit recv_idles;
  int results_seen;

  signed_decimal_field_formatter_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard stop: far beyond the slowest legal run (every character stalled for the longest receiver idle).
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic sdf_tb_pkg::fmt_request_t make_request(int v, bit plus, bit space,
                                                            bit left, bit zpad, bit hasp,
                                                            int prec, int width);
    sdf_tb_pkg::fmt_request_t r;
    r.value = v;
    r.plus  = plus;
    r.space = space;
    r.left  = left;
    r.zpad  = zpad;
    r.hasp  = hasp;
    r.prec  = sdf_pkg::PREC_W'(prec);
    r.width = sdf_pkg::WIDTH_W'(width);
    return r;
  endfunction

  // Mostly short fields with modest precision; now and then the full range,
  // so the saturation paths and every width bit get exercised.
  function automatic sdf_tb_pkg::fmt_request_t random_request();
    sdf_tb_pkg::fmt_request_t r;
    int                       v;
    case ($urandom_range(0, 9))
      0: v = 32'sh8000_0000;
      1: v = 32'sh7FFF_FFFF;
      2: v = $urandom_range(0, 12);
      3, 4: v = $urandom_range(0, 99999);
      default: v = $urandom;
    endcase
    if ($urandom_range(0, 1) && v != 32'sh8000_0000) v = -v;
    r = make_request(v, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                     $urandom_range(0, 1), $urandom_range(0, 1),
                     ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                 : $urandom_range(0, 14),
                     ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
                                                 : $urandom_range(0, 24));
    return r;
  endfunction

  // Drive one request; return in the step it is accepted, valid still high.
  task automatic send_request(sdf_tb_pkg::fmt_request_t r);
    int gap;
    gap = send_idles ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.value         <= r.value;
    in_if.plus_flag     <= r.plus;
    in_if.space_flag    <= r.space;
    in_if.left_flag     <= r.left;
    in_if.zero_flag     <= r.zpad;
    in_if.has_precision <= r.hasp;
    in_if.precision     <= r.prec;
    in_if.min_width     <= r.width;
    do @(posedge clk); while (!in_if.ready);
    sb.note_request(r);
  endtask

  // Drop valid and hold off until every expected character has come back.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Accept characters forever, stalling a random number of cycles before each.
  task automatic collect_results();
    int                    stall;
    sdf_tb_pkg::fmt_char_t got;
    forever begin
      stall = recv_idles ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      got.ch        = out_if.out_char;
      got.ch_valid  = out_if.char_valid;
      got.is_last   = out_if.last;
      got.total_len = out_if.total_length;
      sb.check_char(got);
      results_seen++;
      if (results_seen % 40 == 0) recv_idles = ($urandom_range(0, 3) != 0);
    end
  endtask

  initial begin
    sdf_tb_pkg::fmt_request_t directed[$];
    int                       guard;
    sb = new();
    send_idles   = 1'b1;
    recv_idles   = 1'b1;
    results_seen = 0;

    // Hold every input at a known value through reset.
    rst_n               <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.value         <= '0;
    in_if.plus_flag     <= 1'b0;
    in_if.space_flag    <= 1'b0;
    in_if.left_flag     <= 1'b0;
    in_if.zero_flag     <= 1'b0;
    in_if.has_precision <= 1'b0;
    in_if.precision     <= '0;
    in_if.min_width     <= '0;
    out_if.ready        <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    fork
      collect_results();
    join_none

    // Directed: zero forms, extremes of the value, every flag, saturation.
    directed.push_back(make_request(0, 0, 0, 0, 0, 0, 0, 0));
    // zero precision on zero with no sign and no width: empty marker
    directed.push_back(make_request(0, 0, 0, 0, 0, 1, 0, 0));
    directed.push_back(make_request(0, 1, 0, 0, 0, 1, 0, 0));
    directed.push_back(make_request(0, 0, 1, 0, 0, 1, 0, 5));
    directed.push_back(make_request(0, 0, 0, 1, 0, 1, 0, 3));
    directed.push_back(make_request(0, 0, 0, 0, 0, 1, 1, 0));
    directed.push_back(make_request(32'sh8000_0000, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_request(32'sh7FFF_FFFF, 1, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_request(-1, 0, 0, 0, 1, 0, 0, 8));
    directed.push_back(make_request(42, 0, 0, 0, 1, 1, 5, 10));
    directed.push_back(make_request(42, 0, 0, 1, 1, 0, 0, 10));
    directed.push_back(make_request(7, 0, 1, 0, 0, 0, 0, 0));
    directed.push_back(make_request(7, 1, 1, 0, 0, 0, 0, 0));
    directed.push_back(make_request(-123, 0, 0, 0, 0, 1, 63, 0));
    // oversized width and precision: total pinned at the field limit
    directed.push_back(make_request(5, 1, 0, 0, 0, 1, 63, 127));
    directed.push_back(make_request(123, 0, 0, 0, 0, 0, 0, 127));
    directed.push_back(make_request(32'sh8000_0000, 1, 0, 1, 0, 0, 0, 64));
    directed.push_back(make_request(-99, 0, 0, 0, 1, 0, 0, 64));
    directed.push_back(make_request(1000, 0, 0, 0, 0, 1, 2, 0));
    directed.push_back(make_request(32'sh8000_0000, 0, 0, 0, 1, 1, 63, 100));
    directed.push_back(make_request(32'sh7FFF_FFFF, 1, 1, 1, 1, 1, 63, 127));
    directed.push_back(make_request(32'sh5555_5555, 0, 1, 1, 0, 0, 0, 20));
    directed.push_back(make_request(-32'sh2AAA_AAAA, 0, 0, 0, 0, 1, 12, 16));
    foreach (directed[i]) send_request(directed[i]);
    drain_results();

    // Random part, with a second full drain halfway through.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 20 == 0) send_idles = ($urandom_range(0, 3) != 0);
      if (n == RANDOM_REQUESTS / 2) drain_results();
      send_request(random_request());
    end
    in_if.valid <= 1'b0;

    // Wait out the tail, then give the block time to show stray results.
    guard = 0;
    while (sb.pending() != 0 && guard < DRAIN_CYCLES) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected characters never arrived", sb.pending()));

    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
